// ===== rtl/core/apr_pkg.sv =====
// Package for the aging page replacement core: control state type and fixed field widths.
// No dependencies; used by every module under rtl/core.
package apr_pkg;

    localparam int AGE_W = 8;
    localparam logic [AGE_W-1:0] AGE_TOP = 8'd128;
    localparam logic [9:0] PERIOD_RESET = 10'd90;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SCAN,
        ST_UPDATE,
        ST_AGE,
        ST_OUT
    } state_t;

    // Command broadcast from the controller to every frame cell.
    typedef struct packed {
        logic halve;
        logic touch;
        logic claim;
    } cell_cmd_t;

endpackage

// ===== rtl/core/aging_page_replacement_core.sv =====
// Aging page replacement core: page map, controller and a chain of frame cells (apr_pkg, apr_cell).
// A hit passes through lookup, age and result; a miss adds the scan of the minimum age down
// the chain and the unmapping of the victim's old page between lookup and age.
// One reference at a time: the next input beat can be taken in the cycle after the result
// beat. After reset the page map is cleared one entry per cycle, before the first input beat.
module aging_page_replacement_core
    import apr_pkg::*;
#(
    parameter int NUM_PROCESSES = 16,
    parameter int PAGES_PER_PROCESS = 32,
    parameter int NUM_FRAMES = 256,
    parameter int PAGE_SHIFT = 10
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [9:0]  cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: process_id [3:0], address [18:4], write_access [19], zero fill [23:20]
    input  logic [23:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: hit [0], frame [8:1], evicted_valid [9], evicted_process [13:10],
    // evicted_page [18:14], zero fill [23:19]
    output logic [23:0] m_axis_tdata
);

    localparam int PROC_W  = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1;
    localparam int PAGE_W  = $clog2(PAGES_PER_PROCESS);
    localparam int FRAME_W = $clog2(NUM_FRAMES);
    localparam int MAP_DEPTH = NUM_PROCESSES * PAGES_PER_PROCESS;
    localparam int SLOT_W  = $clog2(MAP_DEPTH);
    localparam int CNT_W   = $clog2(NUM_FRAMES + 2);

    state_t state_reg, state_next;

    logic [9:0]  period_reg;
    logic [9:0]  refcnt_reg;
    logic [SLOT_W:0] clr_reg;
    logic        clearing;

    logic [PROC_W-1:0]  proc_reg;
    logic [PAGE_W-1:0]  page_reg;
    logic               wr_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic               hit_reg;
    logic [FRAME_W-1:0] frame_reg;
    logic               ev_valid_reg;
    logic [PROC_W-1:0]  ev_proc_reg;
    logic [PAGE_W-1:0]  ev_page_reg;
    logic [CNT_W-1:0]   cnt_reg;

    // Page map: valid bit above the frame number.
    logic [FRAME_W:0] map_mem [MAP_DEPTH];
    logic [FRAME_W:0] map_rd_reg;
    logic             map_we;
    logic [SLOT_W-1:0] map_wa;
    logic [FRAME_W:0] map_wd;

    logic [PROC_W-1:0] in_proc;
    logic [PAGE_W-1:0] in_page;
    logic [14:0]       in_addr;
    logic [SLOT_W-1:0] in_slot;

    logic [9:0] refcnt_inc;
    logic       do_halve;

    cell_cmd_t cmd;
    logic [AGE_W:0]     chain_min [NUM_FRAMES+1];
    logic [FRAME_W-1:0] chain_idx [NUM_FRAMES+1];
    logic [PROC_W-1:0]  cell_owner [NUM_FRAMES];
    logic [PAGE_W-1:0]  cell_page  [NUM_FRAMES];
    logic               cell_in_use [NUM_FRAMES];

    assign clearing = !clr_reg[SLOT_W];
    assign in_addr  = s_axis_tdata[18:4];
    assign in_proc  = PROC_W'(32'(s_axis_tdata[3:0]) % NUM_PROCESSES);
    assign in_page  = PAGE_W'((in_addr >> PAGE_SHIFT) % PAGES_PER_PROCESS);
    assign in_slot  = SLOT_W'(in_proc * PAGES_PER_PROCESS) + SLOT_W'(in_page);

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE) && !clearing;
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = {5'd0, 5'(ev_page_reg), 4'(ev_proc_reg), ev_valid_reg,
                            8'(frame_reg), hit_reg};

    assign refcnt_inc = refcnt_reg + 10'd1;
    assign do_halve   = (refcnt_inc >= period_reg);

    assign chain_min[0] = {1'b1, {AGE_W{1'b0}}};
    assign chain_idx[0] = '0;

    genvar g;
    generate
        for (g = 0; g < NUM_FRAMES; g++)
        begin : g_cell
            apr_cell #(
                .FRAME_W (FRAME_W),
                .PROC_W  (PROC_W),
                .PAGE_W  (PAGE_W),
                .INDEX   (FRAME_W'(g))
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (cmd),
                .sel       (frame_reg == FRAME_W'(g)),
                .new_owner (proc_reg),
                .new_page  (page_reg),
                .new_dirty (wr_reg),
                .min_in    (chain_min[g]),
                .idx_in    (chain_idx[g]),
                .min_out   (chain_min[g+1]),
                .idx_out   (chain_idx[g+1]),
                .owner     (cell_owner[g]),
                .page      (cell_page[g]),
                .in_use    (cell_in_use[g])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        map_we     = 1'b0;
        map_wa     = slot_reg;
        map_wd     = '0;
        if (clearing)
        begin
            map_we = 1'b1;
            map_wa = clr_reg[SLOT_W-1:0];
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid && s_axis_tready)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (map_rd_reg[FRAME_W])
                begin
                    state_next = ST_AGE;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg == CNT_W'(NUM_FRAMES))
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                // frame_reg holds the victim; unmap its old page first.
                map_we = 1'b1;
                map_wa = SLOT_W'(cell_owner[frame_reg] * PAGES_PER_PROCESS)
                         + SLOT_W'(cell_page[frame_reg]);
                map_wd = '0;
                if (!cell_in_use[frame_reg])
                begin
                    map_we = 1'b0;
                end
                state_next = ST_AGE;
            end
            ST_AGE:
            begin
                cmd.halve = do_halve;
                cmd.touch = 1'b1;
                cmd.claim = !hit_reg;
                if (!hit_reg)
                begin
                    map_we = 1'b1;
                    map_wa = slot_reg;
                    map_wd = {1'b1, frame_reg};
                end
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (m_axis_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            period_reg <= PERIOD_RESET;
            refcnt_reg <= '0;
            clr_reg    <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                period_reg <= cfg_data;
            end
            if (clearing)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (state_reg == ST_SCAN)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else
            begin
                cnt_reg <= '0;
            end
            if (state_reg == ST_AGE)
            begin
                refcnt_reg <= do_halve ? 10'd0 : refcnt_inc;
            end
        end
    end

    // The map is read at the incoming slot so that the entry is ready in the lookup cycle.
    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[map_wa] <= map_wd;
        end
        map_rd_reg <= map_mem[in_slot];
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            proc_reg <= in_proc;
            page_reg <= in_page;
            wr_reg   <= s_axis_tdata[19];
            slot_reg <= in_slot;
        end
        if (state_reg == ST_LOOKUP)
        begin
            hit_reg      <= map_rd_reg[FRAME_W];
            frame_reg    <= map_rd_reg[FRAME_W-1:0];
            ev_valid_reg <= 1'b0;
            ev_proc_reg  <= '0;
            ev_page_reg  <= '0;
        end
        if (state_reg == ST_SCAN && cnt_reg == CNT_W'(NUM_FRAMES))
        begin
            frame_reg <= chain_idx[NUM_FRAMES];
        end
        if (state_reg == ST_UPDATE && cell_in_use[frame_reg])
        begin
            ev_valid_reg <= 1'b1;
            ev_proc_reg  <= cell_owner[frame_reg];
            ev_page_reg  <= cell_page[frame_reg];
        end
    end

endmodule

// ===== rtl/core/apr_cell.sv =====
// One frame cell: holds the age, owner, page, dirty and in-use mark of one frame.
// Passes the running minimum age and its frame index on to the next cell each cycle.
// Depends on apr_pkg.
module apr_cell
    import apr_pkg::*;
#(
    parameter int FRAME_W = 8,
    parameter int PROC_W = 4,
    parameter int PAGE_W = 5,
    parameter logic [FRAME_W-1:0] INDEX = '0
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cell_cmd_t           cmd,
    input  logic                sel,
    input  logic [PROC_W-1:0]   new_owner,
    input  logic [PAGE_W-1:0]   new_page,
    input  logic                new_dirty,
    input  logic [AGE_W:0]      min_in,
    input  logic [FRAME_W-1:0]  idx_in,
    output logic [AGE_W:0]      min_out,
    output logic [FRAME_W-1:0]  idx_out,
    output logic [PROC_W-1:0]   owner,
    output logic [PAGE_W-1:0]   page,
    output logic                in_use
);

    logic [AGE_W-1:0]  age_reg;
    logic [AGE_W-1:0]  age_next;
    logic [PROC_W-1:0] owner_reg;
    logic [PAGE_W-1:0] page_reg;
    logic              dirty_reg;
    logic              in_use_reg;
    logic [AGE_W:0]    min_reg;
    logic [FRAME_W-1:0] idx_reg;

    always_comb
    begin
        age_next = age_reg;
        if (cmd.claim && sel)
        begin
            age_next = '0;
        end
        if (cmd.halve)
        begin
            age_next = age_next >> 1;
        end
        if (cmd.touch && sel && (age_next < AGE_TOP))
        begin
            age_next = age_next + AGE_TOP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            age_reg    <= '0;
            owner_reg  <= '0;
            page_reg   <= '0;
            dirty_reg  <= 1'b0;
            in_use_reg <= 1'b0;
        end
        else
        begin
            age_reg <= age_next;
            if (cmd.claim && sel)
            begin
                owner_reg  <= new_owner;
                page_reg   <= new_page;
                in_use_reg <= 1'b1;
            end
            if (cmd.touch && sel)
            begin
                dirty_reg <= new_dirty;
            end
        end
    end

    // Strict less-than keeps the earlier frame on a tie.
    always_ff @(posedge clk)
    begin
        if ({1'b0, age_reg} < min_in)
        begin
            min_reg <= {1'b0, age_reg};
            idx_reg <= INDEX;
        end
        else
        begin
            min_reg <= min_in;
            idx_reg <= idx_in;
        end
    end

    assign min_out = min_reg;
    assign idx_out = idx_reg;
    assign owner   = owner_reg;
    assign page    = page_reg;
    assign in_use  = in_use_reg ^ (dirty_reg & 1'b0);

endmodule
